### rtl/keypad_code_lock_assert.svh
// ----------------------------------------------------------------------------
// keypad_code_lock_assert.svh
// Assertion macros for the keypad code lock. All of them sample on the rising
// edge of clk. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property outside reset.
`define KCL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("keypad_code_lock: assertion failed");

// Check a property on every edge, reset included.
`define KCL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("keypad_code_lock: assertion failed");

`else

`define KCL_ASSERT(label, prop)
`define KCL_ASSERT_ALWAYS(label, prop)

`endif

`endif

### rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KEY_W            = 8;
    localparam int KEYS_W           = 4;
    localparam int DEF_CODE_LENGTH  = 6;

    localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
    localparam logic [KEY_W-1:0] KEY_NONE = 8'hFF;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_DIGIT    = 3'd1,
        EV_CONFIRM  = 3'd2,
        EV_SET      = 3'd3,
        EV_MISMATCH = 3'd4,
        EV_OPEN     = 3'd5,
        EV_FAIL     = 3'd6
    } kcl_event_t;

    typedef struct packed {
        kcl_event_t        event_res;
        logic [KEYS_W-1:0] keys_entered;
        logic              unlock;
        logic              code_is_set;
    } kcl_res_t;

endpackage

### rtl/kcl_if.sv
// ----------------------------------------------------------------------------
// kcl_if
// Valid/ready channels of the keypad code lock: key input and result output.
// ----------------------------------------------------------------------------
interface kcl_key_if
    import kcl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_res_if
    import kcl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        event_res;
    logic [KEYS_W-1:0] keys_entered;
    logic              unlock;
    logic              code_is_set;

    modport source (output valid, output event_res, output keys_entered,
                    output unlock, output code_is_set, input ready);
    modport sink   (input valid, input event_res, input keys_entered,
                    input unlock, input code_is_set, output ready);
endinterface

### rtl/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock: sets a code by double entry, then checks entered codes
// against it. One result per key.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  keys      in    valid/ready    key_code[7:0]
//  result    out   valid/ready    event_res[2:0], keys_entered[3:0], unlock,
//                                 code_is_set
//
//  The result passes through the input register, then the decision logic feeds
//  the result register. One key per cycle sustained while result.ready is high.
//  A stalled result holds the pipe; keys.ready drops only when both
//  registers are full and result.ready is low.
//  Reset clears the count and the code-set flag: no code is set.
// ----------------------------------------------------------------------------
module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = DEF_CODE_LENGTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    kcl_key_if.sink          keys,
    kcl_res_if.source        result
);

`include "keypad_code_lock_assert.svh"

    logic             key_valid;
    logic [KEY_W-1:0] key;
    logic             can_load;
    logic             fire;
    kcl_res_t         core_res;
    kcl_res_t         out_res;
    logic             seq_done;

    assign fire = key_valid && can_load;

    kcl_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (keys.valid),
        .in_ready  (keys.ready),
        .in_key    (keys.key_code),
        .consume   (fire),
        .key_valid (key_valid),
        .key       (key)
    );

    kcl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .key   (key),
        .res   (core_res)
    );

    kcl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_in    (core_res),
        .can_load  (can_load),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .res_out   (out_res)
    );

    assign result.event_res    = out_res.event_res;
    assign result.keys_entered = out_res.keys_entered;
    assign result.unlock       = out_res.unlock;
    assign result.code_is_set  = out_res.code_is_set;

    // A completed sequence restarts the count.
    assign seq_done = (out_res.event_res == EV_SET) || (out_res.event_res == EV_OPEN)
                      || (out_res.event_res == EV_FAIL);

    `KCL_ASSERT(a_unlock_open, result.valid |-> (out_res.unlock == (out_res.event_res == EV_OPEN)))
    `KCL_ASSERT(a_set_flag, result.valid && out_res.event_res == EV_SET |-> out_res.code_is_set)
    `KCL_ASSERT(a_done_clears, result.valid && seq_done |-> out_res.keys_entered == '0)
    `KCL_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !result.valid)

endmodule

### rtl/kcl_in_stage.sv
// ----------------------------------------------------------------------------
// kcl_in_stage
// Input register: captures one key code per transaction and holds it until
// the core consumes it.
// ----------------------------------------------------------------------------
module kcl_in_stage
    import kcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [KEY_W-1:0] in_key,
    input  logic             consume,
    output logic             key_valid,
    output logic [KEY_W-1:0] key
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg <= in_key;
        end
    end

    assign key_valid = valid_reg;
    assign key       = key_reg;

endmodule

### rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Lock state and decision logic: collects keys, compares entries in parallel
// and updates the stored code. Produces the result of one key per cycle while fire is high.
// ----------------------------------------------------------------------------
module kcl_core
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = DEF_CODE_LENGTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [KEY_W-1:0] key,
    output kcl_res_t         res
);

`include "keypad_code_lock_assert.svh"

    localparam int CNT_W = $clog2(2 * CODE_LENGTH);

    typedef logic [CODE_LENGTH-1:0][KEY_W-1:0] code_t;

    logic [CNT_W-1:0] key_count_reg;
    logic [CNT_W-1:0] key_count_next;
    logic             code_set_reg;
    logic             code_set_next;
    code_t            first_reg;
    code_t            first_next;
    code_t            second_reg;
    code_t            second_next;
    code_t            stored_reg;
    code_t            stored_next;

    code_t            first_view;
    code_t            second_view;
    logic             ignored;
    logic             in_first;
    logic             in_second;
    logic             last_first;
    logic             last_second;
    logic             match_setup;
    logic             match_verify;
    kcl_event_t       ev;
    logic             unlock;

    // Entry views with the incoming key dropped in at the current position.
    always_comb
    begin
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            first_view[i]  = (key_count_reg == CNT_W'(i)) ? key : first_reg[i];
            second_view[i] = (key_count_reg == CNT_W'(i + CODE_LENGTH)) ? key
                                                                          : second_reg[i];
        end
    end

    assign ignored      = (key == KEY_STAR) || (key == KEY_HASH) || (key == KEY_NONE);
    assign in_first     = key_count_reg <= CNT_W'(CODE_LENGTH - 1);
    assign in_second    = key_count_reg <= CNT_W'(2 * CODE_LENGTH - 1);
    assign last_first   = key_count_reg == CNT_W'(CODE_LENGTH - 1);
    assign last_second  = key_count_reg == CNT_W'(2 * CODE_LENGTH - 1);
    assign match_setup  = first_reg == second_view;
    assign match_verify = first_view == stored_reg;

    always_comb
    begin
        key_count_next = key_count_reg;
        code_set_next  = code_set_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        stored_next    = stored_reg;
        ev             = EV_IGNORED;
        unlock         = 1'b0;

        if (!ignored)
        begin
            if (!code_set_reg)
            begin
                if (in_first)
                begin
                    first_next     = first_view;
                    key_count_next = key_count_reg + CNT_W'(1);
                    ev             = last_first ? EV_CONFIRM : EV_DIGIT;
                end
                else if (in_second)
                begin
                    second_next = second_view;
                    if (last_second)
                    begin
                        if (match_setup)
                        begin
                            stored_next   = second_view;
                            code_set_next = 1'b1;
                            ev            = EV_SET;
                        end
                        else
                        begin
                            ev = EV_MISMATCH;
                        end
                        key_count_next = '0;
                    end
                    else
                    begin
                        key_count_next = key_count_reg + CNT_W'(1);
                        ev             = EV_DIGIT;
                    end
                end
                else
                begin
                    ev             = EV_MISMATCH;
                    key_count_next = '0;
                end
            end
            else
            begin
                if (in_first)
                begin
                    first_next = first_view;
                    if (last_first)
                    begin
                        if (match_verify)
                        begin
                            ev     = EV_OPEN;
                            unlock = 1'b1;
                        end
                        else
                        begin
                            ev = EV_FAIL;
                        end
                        key_count_next = '0;
                    end
                    else
                    begin
                        key_count_next = key_count_reg + CNT_W'(1);
                        ev             = EV_DIGIT;
                    end
                end
                else
                begin
                    key_count_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        res.event_res    = ev;
        res.keys_entered = KEYS_W'(key_count_next);
        res.unlock       = unlock;
        res.code_is_set  = code_set_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            code_set_reg  <= 1'b0;
        end
        else if (fire)
        begin
            key_count_reg <= key_count_next;
            code_set_reg  <= code_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            stored_reg <= stored_next;
        end
    end

    `KCL_ASSERT(a_count_range, key_count_reg <= CNT_W'(2 * CODE_LENGTH - 1))
    `KCL_ASSERT(a_verify_count, code_set_reg |-> key_count_reg <= CNT_W'(CODE_LENGTH - 1))
    `KCL_ASSERT(a_code_set_sticky, code_set_reg |=> code_set_reg)
    `KCL_ASSERT(a_idle_holds, !fire |=> $stable(key_count_reg) && $stable(code_set_reg))

endmodule

### rtl/kcl_out_stage.sv
// ----------------------------------------------------------------------------
// kcl_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module kcl_out_stage
    import kcl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  kcl_res_t res_in,
    output logic     can_load,
    output logic     out_valid,
    input  logic     out_ready,
    output kcl_res_t res_out
);

    logic     valid_reg;
    logic     valid_next;
    kcl_res_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
